// File: rtl/rbst_pkg.sv
// Shared constants for the ray versus box slab test block.
// No dependencies; used by rtl/ray_box_slab_test.sv and tb/sv/testbench.sv.
package rbst_pkg;

   // Configuration register map.
   localparam int unsigned NUM_REGS      = 6;
   localparam int unsigned CSR_IDX_BITS  = 3;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOX_MAX_Z = 3'd5;

   localparam int unsigned NUM_AXES = 3;

endpackage

// File: rtl/rbst_div.sv
// Pipelined saturating fixed-point divider: key = sat(num * 2^F / den), one quotient
// bit per stage. Uses no package items; instantiated by rtl/ray_box_slab_test.sv.
module rbst_div #(
   parameter int CB = 32,
   parameter int F  = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CB+1:0] num,
   input  logic signed [CB-1:0] den,
   output logic signed [CB-1:0] key
);

   localparam int NW    = CB + 1;
   localparam int XW    = NW + F;
   localparam int HW    = F + 2;
   localparam int CW    = (HW > CB) ? HW : CB;
   localparam int STEPS = CB - 1;

   // Magnitude stage.
   logic [NW-1:0] nmag_a_ff;
   logic [CB-1:0] dmag_a_ff;
   logic          neg_a_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_a_ff <= num[CB+1] ? NW'(-num) : NW'(num);
         dmag_a_ff <= den[CB-1] ? CB'(-den) : CB'(den);
         neg_a_ff  <= num[CB+1] ^ den[CB-1];
      end
   end

   // Step registers; entry 0 holds the overflow check and the initial remainder.
   logic [XW-1:0]    x_ff    [0:STEPS];
   logic [CB-1:0]    r_ff    [0:STEPS];
   logic [STEPS-1:0] q_ff    [0:STEPS];
   logic [CB-1:0]    dmag_ff [0:STEPS];
   logic             neg_ff  [0:STEPS];
   logic             ovf_ff  [0:STEPS];

   logic [XW-1:0] x_in;
   logic [HW-1:0] head_in;

   always_comb begin
      x_in    = XW'(nmag_a_ff) << F;
      head_in = x_in[XW-1:CB-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x_in;
         r_ff[0]    <= CB'(head_in);
         q_ff[0]    <= '0;
         dmag_ff[0] <= dmag_a_ff;
         neg_ff[0]  <= neg_a_ff;
         // The quotient saturates when it cannot fit below 2^(CB-1).
         ovf_ff[0]  <= CW'(head_in) >= CW'(dmag_a_ff);
      end
   end

   genvar j;
   generate
      for (j = 1; j <= STEPS; j++) begin : g_step
         logic [CB:0] t;
         logic        ge;
         always_comb begin
            t  = {r_ff[j-1], x_ff[j-1][STEPS-j]};
            ge = t >= {1'b0, dmag_ff[j-1]};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[j]    <= x_ff[j-1];
               r_ff[j]    <= ge ? CB'(t - {1'b0, dmag_ff[j-1]}) : CB'(t);
               q_ff[j]    <= {q_ff[j-1][STEPS-2:0], ge};
               dmag_ff[j] <= dmag_ff[j-1];
               neg_ff[j]  <= neg_ff[j-1];
               ovf_ff[j]  <= ovf_ff[j-1];
            end
         end
      end
   endgenerate

   // Sign and saturation.
   logic signed [CB-1:0] key_in;
   logic signed [CB-1:0] key_ff;

   always_comb begin
      if (neg_ff[STEPS]) begin
         key_in = ovf_ff[STEPS] ? {1'b1, {(CB-1){1'b0}}} : -$signed({1'b0, q_ff[STEPS]});
      end else begin
         key_in = ovf_ff[STEPS] ? {1'b0, {(CB-1){1'b1}}} : $signed({1'b0, q_ff[STEPS]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

// File: rtl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
// Depends on rtl/rbst_pkg.sv and rtl/rbst_div.sv.

// The block takes one ray/object word per cycle and returns one hit word per
// input word, in order. Two stages form the face distances, six dividers retire
// one quotient bit per stage, and three stages order, intersect and compare the
// slab intervals. A new word is accepted in every cycle in which the output
// register is empty or being read; when the output is stalled the whole pipeline
// holds. Box corners come from six configuration registers and should only be
// written while no word is in flight. The whole ray line counts, so boxes behind
// the start still report a hit; an axis with zero direction only rejects when
// the start lies strictly outside that slab.
module ray_box_slab_test #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,

   // Fields from bit 0 up: obj_pos_x, obj_pos_y, obj_pos_z, ray_start_x,
   // ray_start_y, ray_start_z, ray_dir_x, ray_dir_y, ray_dir_z.
   input  logic [((9*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,

   // Fields from bit 0 up: hit.
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,

   input  logic                              csr_we,
   input  logic [rbst_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]             csr_wdata
);

   localparam int CB  = COORD_BITS;
   localparam int NA  = rbst_pkg::NUM_AXES;
   localparam int DL  = CB + 2;       // divider latency
   localparam int LAT = DL + 5;       // total pipeline depth

   // Configuration registers.
   logic signed [CB-1:0] box_min_ff [0:NA-1];
   logic signed [CB-1:0] box_max_ff [0:NA-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            rbst_pkg::REG_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            rbst_pkg::REG_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            rbst_pkg::REG_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            rbst_pkg::REG_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            rbst_pkg::REG_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            rbst_pkg::REG_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves as a whole whenever the output register can take a word.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Valid bits travel alongside the data; the last one is the output valid.
   logic vld_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < LAT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // Stage 1: position minus start, exact.
   logic signed [CB:0]   base1_ff [0:NA-1];
   logic signed [CB-1:0] dir1_ff  [0:NA-1];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NA; a++) begin
            base1_ff[a] <= (CB+1)'($signed(req_tdata[a*CB +: CB]))
                         - (CB+1)'($signed(req_tdata[(3+a)*CB +: CB]));
            dir1_ff[a]  <= $signed(req_tdata[(6+a)*CB +: CB]);
         end
      end
   end

   // Stage 2: distances to both face planes, exact.
   logic signed [CB+1:0] n1_ff   [0:NA-1];
   logic signed [CB+1:0] n2_ff   [0:NA-1];
   logic signed [CB-1:0] dir2_ff [0:NA-1];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NA; a++) begin
            n1_ff[a]   <= (CB+2)'(box_min_ff[a]) + (CB+2)'(base1_ff[a]);
            n2_ff[a]   <= (CB+2)'(box_max_ff[a]) + (CB+2)'(base1_ff[a]);
            dir2_ff[a] <= dir1_ff[a];
         end
      end
   end

   // A zero direction axis rejects when both distances are strictly on the
   // same side, that is when the start lies outside that slab.
   logic [NA-1:0] dz2;
   logic [NA-1:0] zr2;

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         dz2[a] = dir2_ff[a] == '0;
         zr2[a] = (n1_ff[a] > 0 && n2_ff[a] > 0) || (n1_ff[a] < 0 && n2_ff[a] < 0);
      end
   end

   // Zero-direction flags wait beside the dividers.
   logic [NA-1:0] dz_ff [0:DL-1];
   logic [NA-1:0] zr_ff [0:DL-1];

   always_ff @(posedge clock) begin
      if (en) begin
         dz_ff[0] <= dz2;
         zr_ff[0] <= zr2;
         for (int s = 1; s < DL; s++) begin
            dz_ff[s] <= dz_ff[s-1];
            zr_ff[s] <= zr_ff[s-1];
         end
      end
   end

   // Six dividers, one for each face. A zero direction gives a key that is
   // simply ignored later.
   logic signed [CB-1:0] k1 [0:NA-1];
   logic signed [CB-1:0] k2 [0:NA-1];

   genvar g;
   generate
      for (g = 0; g < NA; g++) begin : g_axis
         rbst_div #(.CB(CB), .F(FRAC_BITS)) u_div_min (
            .clock (clock),
            .en    (en),
            .num   (n1_ff[g]),
            .den   (dir2_ff[g]),
            .key   (k1[g])
         );
         rbst_div #(.CB(CB), .F(FRAC_BITS)) u_div_max (
            .clock (clock),
            .en    (en),
            .num   (n2_ff[g]),
            .den   (dir2_ff[g]),
            .key   (k2[g])
         );
      end
   endgenerate

   // Stage 3: order each axis interval. Unused axes widen to the full range.
   logic signed [CB-1:0] lo3_ff [0:NA-1];
   logic signed [CB-1:0] hi3_ff [0:NA-1];
   logic                 rej3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NA; a++) begin
            if (dz_ff[DL-1][a]) begin
               lo3_ff[a] <= {1'b1, {(CB-1){1'b0}}};
               hi3_ff[a] <= {1'b0, {(CB-1){1'b1}}};
            end else if (k1[a] > k2[a]) begin
               lo3_ff[a] <= k2[a];
               hi3_ff[a] <= k1[a];
            end else begin
               lo3_ff[a] <= k1[a];
               hi3_ff[a] <= k2[a];
            end
         end
         rej3_ff <= |(dz_ff[DL-1] & zr_ff[DL-1]);
      end
   end

   // Stage 4: intersect the three intervals.
   logic signed [CB-1:0] lo4_in;
   logic signed [CB-1:0] hi4_in;
   logic signed [CB-1:0] lo4_ff;
   logic signed [CB-1:0] hi4_ff;
   logic                 rej4_ff;

   always_comb begin
      lo4_in = lo3_ff[0];
      hi4_in = hi3_ff[0];
      for (int a = 1; a < NA; a++) begin
         if (lo3_ff[a] > lo4_in) begin
            lo4_in = lo3_ff[a];
         end
         if (hi3_ff[a] < hi4_in) begin
            hi4_in = hi3_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo4_ff  <= lo4_in;
         hi4_ff  <= hi4_in;
         rej4_ff <= rej3_ff;
      end
   end

   // Stage 5: output register. Touching intervals count as a hit.
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= !rej4_ff && (lo4_ff <= hi4_ff);
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {7'b0, hit_ff};

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the ray versus axis-aligned box slab test block.
// Depends on rtl/rbst_pkg.sv and rtl/ray_box_slab_test.sv; reads no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 32;
   localparam int FB = 16;
   localparam int DW = ((9*CB+7)/8)*8;
   localparam int PIPE_DEPTH = CB + 7;
   localparam int HOLD_LEN = 150;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic [rbst_pkg::CSR_IDX_BITS-1:0] csr_idx_type;
   typedef struct packed {
      coord_type dir_z, dir_y, dir_x;
      coord_type start_z, start_y, start_x;
      coord_type pos_z, pos_y, pos_x;
   } ray_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [DW-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   csr_idx_type csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   ray_box_slab_test #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (.*);

   always #6 clock = ~clock;

   // Box corners as the testbench believes them, indexed like the register map.
   coord_type box_corner [rbst_pkg::NUM_REGS];
   ray_word_type pending_rays [$];
   bit expected_hits [$];
   int mismatches = 0;
   int idle_pct = 9;         // percent of cycles each side idles
   bit hold_rsp = 1'b0;      // long receiver stall in progress
   bit req_fire = 1'b0;      // a word was accepted at the last rising edge
   event hold_start;

   // Saturated quotient t = n * 2^FB / d, truncated toward zero. Numerators
   // fit in 34 bits, so a 128-bit signed division is exact.
   function automatic logic signed [63:0] slab_quot(logic signed [127:0] n, coord_type d);
      logic signed [127:0] q;
      q = (n <<< FB) / 128'(signed'(d));
      if (q > 128'sd2147483647) return 64'sd2147483647;
      if (q < -128'sd2147483648) return -64'sd2147483648;
      return 64'(q);
   endfunction

   function automatic bit predict_hit(ray_word_type w);
      coord_type pos [3], st [3], dir [3];
      logic signed [63:0] lo, hi, t1, t2, tt;
      logic signed [127:0] n1, n2;
      bit reject;
      pos = '{w.pos_x, w.pos_y, w.pos_z};
      st  = '{w.start_x, w.start_y, w.start_z};
      dir = '{w.dir_x, w.dir_y, w.dir_z};
      lo = -64'sh4000_0000_0000_0000;
      hi = 64'sh4000_0000_0000_0000;
      reject = 1'b0;
      for (int a = 0; a < 3; a++) begin
         n1 = 128'(box_corner[a]) + 128'(pos[a]) - 128'(st[a]);
         n2 = 128'(box_corner[3+a]) + 128'(pos[a]) - 128'(st[a]);
         if (dir[a] == 0) begin
            if ((n1 > 0 && n2 > 0) || (n1 < 0 && n2 < 0)) reject = 1'b1;
         end else begin
            t1 = slab_quot(n1, dir[a]);
            t2 = slab_quot(n2, dir[a]);
            if (t1 > t2) begin
               tt = t1; t1 = t2; t2 = tt;
            end
            if (t1 > lo) lo = t1;
            if (t2 < hi) hi = t2;
         end
      end
      return !reject && lo <= hi;
   endfunction

   // Driver: presents the oldest pending word, changing inputs at the falling edge.
   // Acceptance is taken from the rising edge, where the handshake is decided.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) void'(pending_rays.pop_front());
         if (pending_rays.size() > 0 && ($urandom_range(99) >= idle_pct ||
               (req_tvalid && !req_fire))) begin
            req_tvalid <= 1'b1;
            req_tdata  <= DW'(pending_rays[0]);
         end else begin
            req_tvalid <= 1'b0;
         end
         if (hold_rsp) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Predict at acceptance so the current box corners apply.
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_hits.push_back(predict_hit(ray_word_type'(req_tdata[9*CB-1:0])));
   end

   // Monitor: compares each accepted hit word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected hit word %0d", rsp_tdata[0]);
         end else if (rsp_tdata[0] !== expected_hits[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Hit mismatch: expected %0d, got %0d", expected_hits[0], rsp_tdata[0]);
            void'(expected_hits.pop_front());
         end else begin
            void'(expected_hits.pop_front());
         end
      end
   end

   // The long receiver stall is counted in cycles in its own process.
   always begin
      @(hold_start);
      hold_rsp = 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp = 1'b0;
   end

   task automatic write_corner(csr_idx_type idx, coord_type v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx < rbst_pkg::NUM_REGS) box_corner[idx] = v;
   endtask

   // Lets every queued word drain, then the pipeline depth on top.
   task automatic drain_pipeline();
      wait (pending_rays.size() == 0 && expected_hits.size() == 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(5))
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(3));
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return coord_type'(int'($urandom_range(20 << 16)) - (10 << 16));
      endcase
   endfunction

   function automatic ray_word_type rand_ray();
      ray_word_type w;
      w.pos_x = rand_coord(); w.pos_y = rand_coord(); w.pos_z = rand_coord();
      w.start_x = rand_coord(); w.start_y = rand_coord(); w.start_z = rand_coord();
      w.dir_x = rand_coord(); w.dir_y = rand_coord(); w.dir_z = rand_coord();
      if ($urandom_range(3) == 0) w.dir_x = 0;
      if ($urandom_range(3) == 0) w.dir_y = 0;
      if ($urandom_range(3) == 0) w.dir_z = 0;
      // Mostly small positions so hits and misses both occur often.
      if ($urandom_range(2) != 0) begin
         w.pos_x = coord_type'(int'($urandom_range(8 << 16)) - (4 << 16));
         w.pos_y = coord_type'(int'($urandom_range(8 << 16)) - (4 << 16));
         w.pos_z = coord_type'(int'($urandom_range(8 << 16)) - (4 << 16));
      end
      return w;
   endfunction

   function automatic ray_word_type make_ray(coord_type px, py, pz, sx, sy, sz, dx, dy, dz);
      ray_word_type w;
      w = '{dz, dy, dx, sz, sy, sx, pz, py, px};
      return w;
   endfunction

   initial begin
      coord_type one;
      coord_type boxes [4][6];
      one = 32'sh0001_0000;
      foreach (box_corner[i]) box_corner[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words against the reset box, a single point at the origin.
      pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_rays.push_back(make_ray(0, 0, 0, one, 0, 0, 0, 0, 0));
      drain_pipeline();

      // Unit box from -1 to 1; directed special cases.
      for (int i = 0; i < 3; i++) write_corner(csr_idx_type'(i), -one);
      for (int i = 3; i < 6; i++) write_corner(csr_idx_type'(i), one);
      write_corner(3'd7, 32'sh1234_5678);   // index past the map is ignored
      // Straight through the center, and in the opposite direction.
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, 0, 0, one, 0, 0));
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, 0, 0, -one, 0, 0));
      // Zero direction, start on a face counts as inside; outside rejects.
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, one, 0, one, 0, 0));
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, one + 1, 0, one, 0, 0));
      // Diagonal that only touches a corner edge.
      pending_rays.push_back(make_ray(0, 0, 0, 0, 2*one, 0, one, -one, 0));
      pending_rays.push_back(make_ray(0, 0, 0, 0, 3*one, 0, one, -one, 0));
      // Tiny directions saturate the quotients.
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, 0, 0, 1, 0, 0));
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, 0, 0, 1, 1, 1));
      pending_rays.push_back(make_ray(0, 0, 0, -5*one, 3*one, 0, 1, -1, 0));
      // Field extremes.
      pending_rays.push_back(make_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0));
      pending_rays.push_back(make_ray(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff,
         32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 32'shffffffff));
      pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      pending_rays.push_back(make_ray(3*one, 0, 0, 0, 0, 0, 0, 0, one));
      drain_pipeline();

      // Random phases over several boxes: swapped corners, extremes, random.
      boxes[0] = '{-2*one, -one, -3*one, 2*one, one, 3*one};
      boxes[1] = '{one, 2*one, one, -one, -2*one, -one};
      boxes[2] = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      boxes[3] = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 0};
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 6; i++)
            write_corner(csr_idx_type'(i), ph < 4 ? boxes[ph][i] : rand_coord());
         // A stretch without idling in the second phase.
         idle_pct = (ph == 1) ? 0 : 9;
         for (int n = 0; n < 115; n++) pending_rays.push_back(rand_ray());
         // Long receiver stall while the sender keeps offering words.
         if (ph == 2) begin
            @(negedge clock);
            -> hold_start;
         end
         drain_pipeline();
      end

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
